/* rtl/lcbt_pkg.sv */
// Shared constants, types and state encoding for the linear complexity block test.
package lcbt_pkg;

  localparam int MaxBlockDef   = 8192;
  localparam int CountWidthDef = 32;

  localparam int CfgW    = 14;
  localparam int LinW    = 14;
  localparam int BinW    = 3;
  localparam int CntOutW = 32;
  localparam int NumBins = 7;
  localparam int MinBlock = 16;

  localparam logic [CfgW-1:0] BlockLenReset = CfgW'(500);

  // Word index of the block length register on the configuration port.
  localparam logic RegBlockLength = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISC,
    ST_DRAIN,
    ST_DECIDE,
    ST_UPD,
    ST_UDRAIN,
    ST_STEP
  } state_e;

  typedef struct packed {
    logic load;        // take the new bit
    logic disc_issue;  // read one discrepancy tap
    logic upd_setup;   // latch update bounds
    logic upd_issue;   // read one update position
    logic upd_commit;  // apply length change
    logic step;        // advance bit position / close block
  } cmd_t;

  typedef struct packed {
    logic l_zero;
    logic disc_last;
    logic upd_last;
    logic d_one;
    logic block_end;
    logic out_stall;
  } sts_t;

endpackage

/* rtl/lcbt_if.sv */
// Valid/ready channel interfaces for the input bits and the per-block results.
interface lcbt_in_if;
  logic valid;
  logic ready;
  logic stream_bit;

  modport source (output valid, output stream_bit, input ready);
  modport sink (input valid, input stream_bit, output ready);
endinterface

interface lcbt_out_if;
  logic                          valid;
  logic                          ready;
  logic [lcbt_pkg::LinW-1:0]    lin_complexity;
  logic [lcbt_pkg::BinW-1:0]    bin_index;
  logic [lcbt_pkg::CntOutW-1:0] bin_count;

  modport source (output valid, output lin_complexity, output bin_index,
                  output bin_count, input ready);
  modport sink (input valid, input lin_complexity, input bin_index,
                input bin_count, output ready);
endinterface

/* rtl/linear_complexity_block_test.sv */
// Top level: APB block length register, sequencer and BM datapath.
// Sequence: when L, the current linear complexity, is zero, the discrepancy pass is
//   skipped; else one discrepancy tap per cycle plus a drain; a discrepancy of one adds
//   an update of U bit positions (U the update length, up to the new L), one per cycle.
// Throughput: one bit at a time; a new bit is taken only after the last one closes.
// Reset: asynchronous, active low; block length 500, counters zero, no memory sweep.
module linear_complexity_block_test #(
  parameter int MAX_BLOCK   = lcbt_pkg::MaxBlockDef,
  parameter int COUNT_WIDTH = lcbt_pkg::CountWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  lcbt_in_if.sink            in_i,
  lcbt_out_if.source         out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int LW = $clog2(MAX_BLOCK + 1);

  logic [lcbt_pkg::CfgW-1:0] block_len_q;
  logic                      cfg_wr;
  logic [31:0]               m_wide;
  logic [LW-1:0]             m_eff;
  lcbt_pkg::cmd_t            cmd;
  lcbt_pkg::sts_t            sts;

  // Decode the register word index only; low address bits are ignored.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == lcbt_pkg::RegBlockLength);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_len_q <= lcbt_pkg::BlockLenReset;
    end else if (cfg_wr) begin
      block_len_q <= pwdata[lcbt_pkg::CfgW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == lcbt_pkg::RegBlockLength) begin
      prdata = 32'(block_len_q);
    end
  end

  // Clamp the block length into the supported range.
  always_comb begin
    if (32'(block_len_q) < 32'(lcbt_pkg::MinBlock)) begin
      m_wide = 32'(lcbt_pkg::MinBlock);
    end else if (32'(block_len_q) > 32'(MAX_BLOCK)) begin
      m_wide = 32'(MAX_BLOCK);
    end else begin
      m_wide = 32'(block_len_q);
    end
  end
  assign m_eff = m_wide[LW-1:0];

  // Sequence each bit transfer through discrepancy, update and close.
  lcbt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold BM state and drive the result register; a write restarts the block.
  lcbt_datapath #(
    .MAX_BLOCK   (MAX_BLOCK),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .bit_i       (in_i.stream_bit),
    .m_i         (m_eff),
    .restart_i   (cfg_wr),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .lin_o       (out_o.lin_complexity),
    .bin_o       (out_o.bin_index),
    .count_o     (out_o.bin_count)
  );

endmodule

/* rtl/lcbt_ctrl.sv */
// Sequencer for one bit: discrepancy pass, polynomial update, block close.
module lcbt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  lcbt_pkg::sts_t sts_i,
  output lcbt_pkg::cmd_t cmd_o
);

  lcbt_pkg::state_e state_q, state_d;
  logic accept;

  assign accept = in_valid_i && (state_q == lcbt_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lcbt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lcbt_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = sts_i.l_zero ? lcbt_pkg::ST_DECIDE : lcbt_pkg::ST_DISC;
        end
      end
      lcbt_pkg::ST_DISC: begin
        if (sts_i.disc_last) state_d = lcbt_pkg::ST_DRAIN;
      end
      lcbt_pkg::ST_DRAIN:  state_d = lcbt_pkg::ST_DECIDE;
      lcbt_pkg::ST_DECIDE: state_d = sts_i.d_one ? lcbt_pkg::ST_UPD : lcbt_pkg::ST_STEP;
      lcbt_pkg::ST_UPD: begin
        if (sts_i.upd_last) state_d = lcbt_pkg::ST_UDRAIN;
      end
      lcbt_pkg::ST_UDRAIN: state_d = lcbt_pkg::ST_STEP;
      lcbt_pkg::ST_STEP: begin
        if (!(sts_i.block_end && sts_i.out_stall)) state_d = lcbt_pkg::ST_IDLE;
      end
      default: state_d = lcbt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      lcbt_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = accept;
      end
      lcbt_pkg::ST_DISC:   cmd_o.disc_issue = 1'b1;
      lcbt_pkg::ST_DRAIN:  ;
      lcbt_pkg::ST_DECIDE: cmd_o.upd_setup = sts_i.d_one;
      lcbt_pkg::ST_UPD:    cmd_o.upd_issue = 1'b1;
      lcbt_pkg::ST_UDRAIN: cmd_o.upd_commit = 1'b1;
      lcbt_pkg::ST_STEP:   cmd_o.step = !(sts_i.block_end && sts_i.out_stall);
      default: ;
    endcase
  end

endmodule

/* rtl/lcbt_datapath.sv */
// Bit store, ping-pong polynomial banks, BM registers, classifier and bin counters.
module lcbt_datapath #(
  parameter int MAX_BLOCK   = lcbt_pkg::MaxBlockDef,
  parameter int COUNT_WIDTH = lcbt_pkg::CountWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lcbt_pkg::cmd_t                cmd_i,
  output lcbt_pkg::sts_t                sts_o,
  input  logic                          bit_i,
  input  logic [$clog2(MAX_BLOCK+1)-1:0] m_i,
  input  logic                          restart_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [lcbt_pkg::LinW-1:0]     lin_o,
  output logic [lcbt_pkg::BinW-1:0]     bin_o,
  output logic [lcbt_pkg::CntOutW-1:0]  count_o
);

  localparam int AW = $clog2(MAX_BLOCK);
  localparam int LW = $clog2(MAX_BLOCK + 1);
  localparam int TW = LW + 9;

  logic store_mem [MAX_BLOCK];
  logic bank0_mem [MAX_BLOCK];
  logic bank1_mem [MAX_BLOCK];

  logic [LW-1:0] n_q, l_q, lb_q, p_q, j_q, t_q, tlo_q, shift_q;
  logic          ptr_q, swap_q, d_q, disc_v_q, upd_v_q;
  logic          cmask_q, bmask_q, bone_q;
  logic [AW-1:0] wa_q;
  logic          s_rd_q, b0_rd_q, b1_rd_q;
  logic [COUNT_WIDTH-1:0] cnt_q [lcbt_pkg::NumBins];

  logic          out_valid_q;
  logic [lcbt_pkg::LinW-1:0]    lin_q;
  logic [lcbt_pkg::BinW-1:0]    bin_q;
  logic [lcbt_pkg::CntOutW-1:0] count_q;

  logic [LW-1:0] n_inc, shift_new, l_new, c_ra, b_ra, k_idx;
  logic          swap_new, c_rd, b_rd, upd_val, wr_bank;
  logic [AW-1:0] ra0, ra1, s_ra;
  logic          block_end;

  assign n_inc     = LW'(n_q + 1'b1);
  assign shift_new = LW'(n_inc - p_q);
  assign l_new     = LW'(n_inc - l_q);
  assign swap_new  = (l_q <= (n_q >> 1));
  assign block_end = (n_inc == m_i);

  // Read addresses: connection bank at j or t, previous bank at t - shift.
  assign c_ra  = cmd_i.upd_issue ? t_q : j_q;
  assign k_idx = LW'(t_q - shift_q);
  assign b_ra  = k_idx;
  assign ra0   = ptr_q ? b_ra[AW-1:0] : c_ra[AW-1:0];
  assign ra1   = ptr_q ? c_ra[AW-1:0] : b_ra[AW-1:0];
  assign s_ra  = AW'(n_q - j_q);

  assign c_rd = ptr_q ? b1_rd_q : b0_rd_q;
  assign b_rd = ptr_q ? b0_rd_q : b1_rd_q;

  // Masked terms: entries past the tracked degree read as zero, index zero as one.
  assign upd_val = (cmask_q & c_rd) ^ (bmask_q & (bone_q | b_rd));
  assign wr_bank = swap_q ? ~ptr_q : ptr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) store_mem[n_q[AW-1:0]] <= bit_i;
    s_rd_q <= store_mem[s_ra];
  end

  always_ff @(posedge clk_i) begin
    if (upd_v_q && !wr_bank) bank0_mem[wa_q] <= upd_val;
    b0_rd_q <= bank0_mem[ra0];
  end

  always_ff @(posedge clk_i) begin
    if (upd_v_q && wr_bank) bank1_mem[wa_q] <= upd_val;
    b1_rd_q <= bank1_mem[ra1];
  end

  // Classification of L into the seven deviation bins.
  logic signed [TW-1:0] l_ext, m_ext, t36;
  logic [lcbt_pkg::BinW-1:0] bin_sel;
  logic [COUNT_WIDTH-1:0]    cnt_new;
  logic [COUNT_WIDTH+lcbt_pkg::CntOutW-1:0] cnt_wide;

  always_comb begin
    l_ext = TW'(l_q);
    m_ext = TW'(m_i);
    if (m_i[0]) begin
      t36 = -((l_ext <<< 5) + (l_ext <<< 2)) + (m_ext <<< 4) + (m_ext <<< 1) + TW'(16);
    end else begin
      t36 = (l_ext <<< 5) + (l_ext <<< 2) - (m_ext <<< 4) - (m_ext <<< 1) - TW'(2);
    end
    if (t36 <= TW'(-90))      bin_sel = 3'd0;
    else if (t36 <= TW'(-54)) bin_sel = 3'd1;
    else if (t36 <= TW'(-18)) bin_sel = 3'd2;
    else if (t36 <= TW'(18))  bin_sel = 3'd3;
    else if (t36 <= TW'(54))  bin_sel = 3'd4;
    else if (t36 <= TW'(90))  bin_sel = 3'd5;
    else                      bin_sel = 3'd6;
    cnt_new  = (cnt_q[bin_sel] == '1) ? cnt_q[bin_sel] : cnt_q[bin_sel] + 1'b1;
    cnt_wide = {{lcbt_pkg::CntOutW{1'b0}}, cnt_new};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q      <= '0;
      l_q      <= '0;
      lb_q     <= '0;
      p_q      <= '0;
      ptr_q    <= 1'b0;
      disc_v_q <= 1'b0;
      upd_v_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int b = 0; b < lcbt_pkg::NumBins; b++) cnt_q[b] <= '0;
    end else begin
      disc_v_q <= cmd_i.disc_issue;
      upd_v_q  <= cmd_i.upd_issue;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.upd_commit && swap_q) begin
        l_q   <= l_new;
        lb_q  <= l_q;
        p_q   <= n_inc;
        ptr_q <= ~ptr_q;
      end
      if (cmd_i.step) begin
        if (block_end) begin
          cnt_q[bin_sel] <= cnt_new;
          out_valid_q    <= 1'b1;
          n_q  <= '0;
          l_q  <= '0;
          lb_q <= '0;
          p_q  <= '0;
        end else begin
          n_q <= n_inc;
        end
      end
      if (restart_i) begin
        n_q  <= '0;
        l_q  <= '0;
        lb_q <= '0;
        p_q  <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      d_q <= bit_i;
      j_q <= LW'(1);
    end else if (disc_v_q) begin
      d_q <= d_q ^ (s_rd_q & c_rd);
    end
    if (cmd_i.disc_issue) j_q <= LW'(j_q + 1'b1);
    if (cmd_i.upd_setup) begin
      shift_q <= shift_new;
      swap_q  <= swap_new;
      t_q     <= swap_new ? l_new : LW'(shift_new + lb_q);
      tlo_q   <= swap_new ? LW'(1) : shift_new;
    end
    if (cmd_i.upd_issue) begin
      cmask_q <= (t_q <= l_q);
      bmask_q <= (t_q >= shift_q) && (k_idx <= lb_q);
      bone_q  <= (k_idx == '0);
      wa_q    <= t_q[AW-1:0];
      t_q     <= LW'(t_q - 1'b1);
    end
    if (cmd_i.step && block_end) begin
      lin_q   <= lcbt_pkg::LinW'(l_q);
      bin_q   <= bin_sel;
      count_q <= cnt_wide[lcbt_pkg::CntOutW-1:0];
    end
  end

  assign sts_o.l_zero    = (l_q == '0);
  assign sts_o.disc_last = (j_q == l_q);
  assign sts_o.upd_last  = (t_q == tlo_q);
  assign sts_o.d_one     = d_q;
  assign sts_o.block_end = block_end;
  assign sts_o.out_stall = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign lin_o       = lin_q;
  assign bin_o       = bin_q;
  assign count_o     = count_q;

endmodule

/* rtl/lcbt_checker.sv */
// Port-level checks for the linear complexity block test, bound to the top level.
module lcbt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  bin_index_i,
  input logic [31:0] bin_count_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("bit taken while previous bit still in work");

  a_bin_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> bin_index_i <= 3'd6)
    else $error("bin index out of range");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> bin_count_i != 32'd0)
    else $error("bin count zero on result");

endmodule

bind linear_complexity_block_test lcbt_checker u_lcbt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .bin_index_i (out_o.bin_index),
  .bin_count_i (out_o.bin_count)
);
